[src/assert_macros.svh]
// Assertion macros shared by the gesture classifier RTL.
// Depends on nothing; included by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed: label");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

[src/gfc_pkg.sv]
// Types, codes and the per-foot event function of the footswitch gesture classifier.
// Depends on nothing; imported by footswitch_gesture_classifier, gfc_cfg and gfc_logic.
`timescale 1ns / 1ps

package gfc_pkg;

  localparam int unsigned SWITCH_COUNT = 16;
  localparam int unsigned APB_ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_ON_IDX   = 3'd0,
    REG_AUX_IDX  = 3'd1,
    REG_UP_IDX   = 3'd2,
    REG_DOWN_IDX = 3'd3,
    REG_HOLD     = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    EK_PRESS   = 3'd0,
    EK_SHORT   = 3'd1,
    EK_HOLD    = 3'd2,
    EK_RELEASE = 3'd3,
    EK_REPEAT  = 3'd4
  } event_kind_t;

  typedef enum logic [2:0] {
    GC_ON_SHORT  = 3'd0,
    GC_AUX_SHORT = 3'd1,
    GC_ON_HOLD   = 3'd2,
    GC_AUX_HOLD  = 3'd3,
    GC_BOTH_HOLD = 3'd4,
    GC_MODE_UP   = 3'd5,
    GC_MODE_DOWN = 3'd6
  } gesture_code_t;

  typedef struct packed {
    logic [3:0]  on_idx;
    logic [3:0]  aux_idx;
    logic [3:0]  up_idx;
    logic [3:0]  down_idx;
    logic [30:0] hold_time_us;
  } cfg_t;

  typedef struct packed {
    logic        on_down;
    logic        aux_down;
    logic        chord_active;
    logic        chord_settled;
    logic        single_hold_fired;
    logic [31:0] chord_start_us;
  } st_t;

  typedef struct packed {
    logic        func;
    logic [31:0] now_us;
    logic [3:0]  switch_index;
    logic [2:0]  event_kind;
    logic [31:0] press_time_us;
  } item_t;

  typedef struct packed {
    logic [2:0]  gesture_code;
    logic [31:0] gesture_time_us;
  } res_t;

  typedef struct packed {
    st_t        st;
    logic       hit;
    logic [2:0] code;
  } foot_res_t;

  // One event on one foot, applied to the state as it stands.
  function automatic foot_res_t foot_apply(st_t s, logic is_aux, logic [2:0] kind,
                                           logic [31:0] press);
    foot_res_t r;
    logic      other_down;
    r.st = s;
    r.hit = 1'b0;
    r.code = GC_ON_SHORT;
    other_down = is_aux ? s.on_down : s.aux_down;
    case (kind)
      EK_PRESS: begin
        if (is_aux) r.st.aux_down = 1'b1;
        else r.st.on_down = 1'b1;
        if (other_down && !s.chord_active) begin
          r.st.chord_active = 1'b1;
          r.st.chord_start_us = press;
          r.st.chord_settled = s.single_hold_fired;
        end
      end
      EK_SHORT: begin
        if (!s.chord_active) begin
          r.hit = 1'b1;
          r.code = is_aux ? GC_AUX_SHORT : GC_ON_SHORT;
        end
      end
      EK_HOLD: begin
        if (!s.chord_active) begin
          r.st.single_hold_fired = 1'b1;
          r.hit = 1'b1;
          r.code = is_aux ? GC_AUX_HOLD : GC_ON_HOLD;
        end
      end
      EK_RELEASE: begin
        if (is_aux) r.st.aux_down = 1'b0;
        else r.st.on_down = 1'b0;
        r.st.chord_settled = 1'b1;
        if (!other_down) begin
          r.st.chord_active = 1'b0;
          r.st.chord_settled = 1'b0;
          r.st.single_hold_fired = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

endpackage

[src/gfc_in_if.sv]
// Stream interface that carries switch events and time checks into the classifier.
// Depends on nothing.
`timescale 1ns / 1ps

interface gfc_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] now_us;
  logic [3:0]  switch_index;
  logic [2:0]  event_kind;
  logic [31:0] press_time_us;

  modport source (output valid, func, now_us, switch_index, event_kind, press_time_us,
                  input ready);
  modport sink (input valid, func, now_us, switch_index, event_kind, press_time_us,
                output ready);
endinterface

[src/gfc_out_if.sv]
// Stream interface that carries gestures out of the classifier.
// Depends on nothing.
`timescale 1ns / 1ps

interface gfc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  gesture_code;
  logic [31:0] gesture_time_us;

  modport source (output valid, gesture_code, gesture_time_us, input ready);
  modport sink (input valid, gesture_code, gesture_time_us, output ready);
endinterface

[src/footswitch_gesture_classifier.sv]
// A word accepted at the input passes the input register and then the result register on
// its way to the output. Throughput: one word per cycle while the output is not stalled; the state
// update is a single pass of gfc_logic between the input register and the result register.
// A stalled result stops the input register only once it too is full.
// Reset (rst, synchronous, active high) clears both registers' valid bits, the foot
// and chord state, and loads the configuration defaults.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module footswitch_gesture_classifier
  import gfc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  gfc_in_if.sink                events,
  gfc_out_if.source             gestures,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t  cfg;
  st_t   st;
  st_t   st_next;
  item_t stage;
  logic  stage_valid;
  logic  advance;
  logic  hit;
  res_t  res_next;
  res_t  out_res;
  logic  out_valid;

  gfc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gfc_logic u_logic (
    .cfg     (cfg),
    .st      (st),
    .item    (stage),
    .st_next (st_next),
    .hit     (hit),
    .res     (res_next)
  );

  // The staged word is processed once the result register can take its gesture.
  assign advance       = !out_valid || gestures.ready;
  assign events.ready  = !stage_valid || advance;

  assign gestures.valid           = out_valid;
  assign gestures.gesture_code    = out_res.gesture_code;
  assign gestures.gesture_time_us = out_res.gesture_time_us;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
      st          <= '0;
    end else begin
      if (events.valid && events.ready) begin
        stage_valid         <= 1'b1;
        stage.func          <= events.func;
        stage.now_us        <= events.now_us;
        stage.switch_index  <= events.switch_index;
        stage.event_kind    <= events.event_kind;
        stage.press_time_us <= events.press_time_us;
      end else if (advance) begin
        stage_valid <= 1'b0;
      end
      if (stage_valid && advance) begin
        st        <= st_next;
        out_valid <= hit;
        if (hit) out_res <= res_next;
      end else if (gestures.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `ASSERT_ALWAYS(a_chord_needs_foot, clk, rst, !st.chord_active || st.on_down || st.aux_down)
  `ASSERT_NEXT(a_stage_held, clk, rst, stage_valid && !advance, stage_valid)
  `ASSERT_NEXT(a_both_hold_settles, clk, rst, stage_valid && advance && hit && res_next.gesture_code == GC_BOTH_HOLD, st.chord_settled)

endmodule

[src/gfc_cfg.sv]
// APB-style configuration registers of the gesture classifier.
// Depends on gfc_pkg.
`timescale 1ns / 1ps

module gfc_cfg
  import gfc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [2:0] reg_sel;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_sel = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.on_idx       <= 4'd0;
      cfg.aux_idx      <= 4'd1;
      cfg.up_idx       <= 4'd2;
      cfg.down_idx     <= 4'd3;
      cfg.hold_time_us <= 31'd500000;
    end else if (wr_en) begin
      case (reg_sel)
        REG_ON_IDX:   cfg.on_idx       <= pwdata[3:0];
        REG_AUX_IDX:  cfg.aux_idx      <= pwdata[3:0];
        REG_UP_IDX:   cfg.up_idx       <= pwdata[3:0];
        REG_DOWN_IDX: cfg.down_idx     <= pwdata[3:0];
        REG_HOLD:     cfg.hold_time_us <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ON_IDX:   prdata = {28'd0, cfg.on_idx};
      REG_AUX_IDX:  prdata = {28'd0, cfg.aux_idx};
      REG_UP_IDX:   prdata = {28'd0, cfg.up_idx};
      REG_DOWN_IDX: prdata = {28'd0, cfg.down_idx};
      REG_HOLD:     prdata = {1'b0, cfg.hold_time_us};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

[src/gfc_logic.sv]
// Combinational classifier: next state and gesture for one word.
// Depends on gfc_pkg (types, codes and foot_apply).
`timescale 1ns / 1ps

module gfc_logic
  import gfc_pkg::*;
(
  input  cfg_t  cfg,
  input  st_t   st,
  input  item_t item,
  output st_t   st_next,
  output logic  hit,
  output res_t  res
);

  logic [31:0] deadline;
  logic [31:0] diff;
  logic        idx_ok;
  logic        is_step;
  foot_res_t   on_r;
  foot_res_t   aux_r;

  assign deadline = st.chord_start_us + {1'b0, cfg.hold_time_us};
  assign diff     = item.now_us - deadline;
  assign idx_ok   = {5'd0, item.switch_index} < 9'(SWITCH_COUNT);
  assign is_step  = item.event_kind inside {EK_SHORT, EK_HOLD, EK_REPEAT};

  // The main foot sees the event first; the aux foot sees the state it leaves.
  always_comb begin
    on_r = foot_apply(st, 1'b0, item.event_kind, item.press_time_us);
    if (item.switch_index != cfg.on_idx) begin
      on_r.st  = st;
      on_r.hit = 1'b0;
    end
    aux_r = foot_apply(on_r.st, 1'b1, item.event_kind, item.press_time_us);
    if (item.switch_index != cfg.aux_idx || on_r.hit) begin
      aux_r.st  = on_r.st;
      aux_r.hit = 1'b0;
    end
  end

  always_comb begin
    st_next = st;
    hit = 1'b0;
    res.gesture_code = GC_BOTH_HOLD;
    res.gesture_time_us = item.press_time_us;
    if (!item.func) begin
      if (st.chord_active && !st.chord_settled && !diff[31]) begin
        st_next.chord_settled = 1'b1;
        hit = 1'b1;
        res.gesture_time_us = st.chord_start_us;
      end
    end else if (idx_ok) begin
      st_next = aux_r.st;
      if (on_r.hit) begin
        hit = 1'b1;
        res.gesture_code = on_r.code;
      end else if (aux_r.hit) begin
        hit = 1'b1;
        res.gesture_code = aux_r.code;
      end else if (is_step && item.switch_index == cfg.up_idx) begin
        hit = 1'b1;
        res.gesture_code = GC_MODE_UP;
      end else if (is_step && item.switch_index == cfg.down_idx) begin
        hit = 1'b1;
        res.gesture_code = GC_MODE_DOWN;
      end
    end
  end

endmodule
